>>> hdl/dafp_pkg.sv
package dafp_pkg;

    // widths of the fixed datapath, set by the Q15.16 inputs scaled to 30 bits
    localparam int SC_W   = 32;    // scaled difference component, signed
    localparam int SC_LEN = 30;    // bit length targeted by the scaling
    localparam int CR_W   = 63;    // cross product component, signed
    localparam int MG_W   = 62;    // cross product magnitude
    localparam int HF_W   = 31;    // multiplier operand chunk
    localparam int PP_W   = 62;    // chunk product
    localparam int BB_W   = 64;    // squared length of b, square root work width
    localparam int X_W    = 126;   // (a x b) . (b x c), signed
    localparam int XT_W   = 125;   // one signed term of x
    localparam int T_W    = 95;    // a . (b x c), signed
    localparam int TT_W   = 93;    // one signed term of t
    localparam int PX_W   = 124;   // one unsigned term of x, also |x| and |y|
    localparam int PT_W   = 92;    // one unsigned term of t
    localparam int TM_W   = 93;    // |t|
    localparam int RB_W   = 31;    // |b|
    localparam int LN_W   = 8;     // bit length of up to 128 bits
    localparam int OP_W   = 30;    // cordic operand magnitude
    localparam int CD_W   = 34;    // cordic x, y and angle accumulator
    localparam int ANG_W  = 19;
    localparam int RND_SH = 14;
    localparam int ANG_MAX = 205888;
    localparam int SQ_N   = 32;    // square root steps, one result bit each

    localparam logic signed [CD_W-1:0] PI_Q30 = 34'sh0_C90F_DAA2;

    localparam int ATAN_N = 32;
    localparam logic [31:0] ATAN_TAB [ATAN_N] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
        32'h00000001, 32'h00000000
    };

    // cross products, scaled a and squared length of b
    typedef struct packed {
        logic                      valid;
        logic [2:0][CR_W-1:0]      n1;
        logic [2:0][CR_W-1:0]      n2;
        logic [2:0][SC_W-1:0]      a;
        logic [BB_W-1:0]           bb;
    } t_cross;

    // dot products, squared length of b
    typedef struct packed {
        logic             valid;
        logic [X_W-1:0]   x;
        logic [T_W-1:0]   t;
        logic [BB_W-1:0]  bb;
    } t_dot;

    // dot products and |b|
    typedef struct packed {
        logic             valid;
        logic [X_W-1:0]   x;
        logic [T_W-1:0]   t;
        logic [RB_W-1:0]  rb;
    } t_root;

    // normalized cordic operands
    typedef struct packed {
        logic             valid;
        logic             zero;
        logic             xneg;
        logic [OP_W-1:0]  xs;
        logic [OP_W:0]    ys;    // signed
    } t_norm;

    function automatic logic [LN_W-1:0] bitlen128(input logic [127:0] v);
        logic [LN_W-1:0] n;
        n = '0;
        for (int i = 0; i < 128; i++) begin
            if (v[i]) begin
                n = LN_W'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

>>> hdl/dafp_pts_if.sv
interface dafp_pts_if #(
    parameter int COORD_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] first_x;
    logic signed [COORD_WIDTH-1:0] first_y;
    logic signed [COORD_WIDTH-1:0] first_z;
    logic signed [COORD_WIDTH-1:0] second_x;
    logic signed [COORD_WIDTH-1:0] second_y;
    logic signed [COORD_WIDTH-1:0] second_z;
    logic signed [COORD_WIDTH-1:0] third_x;
    logic signed [COORD_WIDTH-1:0] third_y;
    logic signed [COORD_WIDTH-1:0] third_z;
    logic signed [COORD_WIDTH-1:0] fourth_x;
    logic signed [COORD_WIDTH-1:0] fourth_y;
    logic signed [COORD_WIDTH-1:0] fourth_z;

    modport source (
        output valid, first_x, first_y, first_z, second_x, second_y, second_z,
               third_x, third_y, third_z, fourth_x, fourth_y, fourth_z,
        input  ready
    );
    modport sink (
        input  valid, first_x, first_y, first_z, second_x, second_y, second_z,
               third_x, third_y, third_z, fourth_x, fourth_y, fourth_z,
        output ready
    );
endinterface

>>> hdl/dafp_ang_if.sv
interface dafp_ang_if;
    logic                            valid;
    logic                            ready;
    logic signed [dafp_pkg::ANG_W-1:0] torsion_angle;

    modport source (output valid, torsion_angle, input ready);
    modport sink   (input valid, torsion_angle, output ready);
endinterface

>>> hdl/dihedral_angle_four_points_top.sv
// channel  | dir | handshake            | payload
// i_pt     | in  | valid / ready        | first_x .. fourth_z, signed Q15.16
// o_ang    | out | valid / ready        | torsion_angle, signed radians, lsb 2^-16
//
// one item enters per cycle while o_ang is not stalled; the path runs through the front,
// the dot products, the 32 stage square root, the norm stage and the cordic stages
// reset: synchronous active low i_rst_n clears every valid bit, payload is not reset
// stalls: the whole pipeline holds while a result sits on o_ang unaccepted
// bubbles travel as cleared valid bits, so nothing is lost or repeated
module dihedral_angle_four_points_top #(
    parameter int COORD_WIDTH      = 32,
    parameter int ANGLE_ITERATIONS = 20
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    dafp_pts_if.sink          i_pt,
    dafp_ang_if.source        o_ang
);
    logic                     en;
    logic [COORD_WIDTH-1:0]   pts [12];
    dafp_pkg::t_cross         cross_s;
    dafp_pkg::t_dot           dot_s;
    dafp_pkg::t_root          root_s;
    dafp_pkg::t_norm          norm_s;
    logic                     out_valid;
    logic signed [dafp_pkg::ANG_W-1:0] out_angle;

    // pipeline advances unless the output register holds an untaken item
    assign en         = !out_valid || o_ang.ready;
    assign i_pt.ready = en;

    assign pts[0]  = i_pt.first_x;
    assign pts[1]  = i_pt.first_y;
    assign pts[2]  = i_pt.first_z;
    assign pts[3]  = i_pt.second_x;
    assign pts[4]  = i_pt.second_y;
    assign pts[5]  = i_pt.second_z;
    assign pts[6]  = i_pt.third_x;
    assign pts[7]  = i_pt.third_y;
    assign pts[8]  = i_pt.third_z;
    assign pts[9]  = i_pt.fourth_x;
    assign pts[10] = i_pt.fourth_y;
    assign pts[11] = i_pt.fourth_z;

    // differences, per vector scaling, cross products and |b|^2
    dafp_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_pt.valid && en),
        .i_p     (pts),
        .o_cross (cross_s)
    );

    // x = (a x b) . (b x c) and t = a . (b x c) from 31 bit chunk products
    dafp_dot u_dot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_cross (cross_s),
        .o_dot   (dot_s)
    );

    // |b| by restoring square root, one bit per stage
    dafp_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_dot   (dot_s),
        .o_root  (root_s)
    );

    // y = |b| * t, then common scaling of x and y to 30 bits
    dafp_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_root  (root_s),
        .o_norm  (norm_s)
    );

    // vectoring cordic, rounding and the output register
    dafp_cordic #(
        .ANGLE_ITERATIONS (ANGLE_ITERATIONS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_norm  (norm_s),
        .o_valid (out_valid),
        .o_angle (out_angle)
    );

    assign o_ang.valid         = out_valid;
    assign o_ang.torsion_angle = out_angle;

endmodule

>>> hdl/dafp_front.sv
module dafp_front #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic [COORD_WIDTH-1:0] i_p [12],
    output dafp_pkg::t_cross       o_cross
);
    localparam int DW = COORD_WIDTH + 1;
    localparam int WW = COORD_WIDTH + dafp_pkg::SC_W;
    localparam int LW = $clog2(DW + 1);
    localparam int NX [3] = '{1, 2, 0};
    localparam int NY [3] = '{2, 0, 1};

    logic [3:0]                       r_v;
    logic [DW-1:0]                    r_d   [9];
    logic [DW-1:0]                    r_d2  [9];
    logic [LW-1:0]                    r_len [3];
    logic signed [dafp_pkg::SC_W-1:0] r_s   [9];
    logic signed [63:0]               r_pm  [15];
    logic [dafp_pkg::SC_W-1:0]        r_a   [3];

    logic [DW-1:0]                    n_d   [9];
    logic [LW-1:0]                    n_len [3];
    logic signed [dafp_pkg::SC_W-1:0] n_s   [9];
    logic signed [63:0]               n_pm  [15];
    dafp_pkg::t_cross                 n_cross;
    dafp_pkg::t_cross                 r_cross;

    // differences: a, b, c
    always_comb begin
        for (int k = 0; k < 9; k++) begin
            n_d[k] = {i_p[k + 3][COORD_WIDTH-1], i_p[k + 3]}
                   - {i_p[k][COORD_WIDTH-1], i_p[k]};
        end
    end

    // bit length of the largest component magnitude per vector
    always_comb begin
        logic [DW-1:0] mor;
        logic [DW-1:0] mg;
        for (int v = 0; v < 3; v++) begin
            mor = '0;
            for (int c = 0; c < 3; c++) begin
                mg  = r_d[v*3 + c][DW-1] ? (~r_d[v*3 + c] + 1'b1) : r_d[v*3 + c];
                mor = mor | mg;
            end
            n_len[v] = LW'(dafp_pkg::bitlen128(128'(mor)));
        end
    end

    // power of two scaling to a 30 bit length
    always_comb begin
        logic [WW-1:0] ext;
        logic [WW-1:0] sh;
        int            l;
        for (int v = 0; v < 3; v++) begin
            for (int c = 0; c < 3; c++) begin
                l   = int'(r_len[v]);
                ext = {{(WW-DW){r_d2[v*3 + c][DW-1]}}, r_d2[v*3 + c]};
                if (l > dafp_pkg::SC_LEN) begin
                    sh = $signed(ext) >>> (l - dafp_pkg::SC_LEN);
                end else begin
                    sh = ext << (dafp_pkg::SC_LEN - l);
                end
                n_s[v*3 + c] = sh[dafp_pkg::SC_W-1:0];
            end
        end
    end

    // products: a x b, b x c and b . b
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_pm[2*k]     = r_s[NX[k]]     * r_s[3 + NY[k]];
            n_pm[2*k + 1] = r_s[NY[k]]     * r_s[3 + NX[k]];
            n_pm[6 + 2*k] = r_s[3 + NX[k]] * r_s[6 + NY[k]];
            n_pm[7 + 2*k] = r_s[3 + NY[k]] * r_s[6 + NX[k]];
            n_pm[12 + k]  = r_s[3 + k]     * r_s[3 + k];
        end
    end

    always_comb begin
        logic [63:0] dn1;
        logic [63:0] dn2;
        n_cross.valid = r_v[3];
        for (int k = 0; k < 3; k++) begin
            dn1 = r_pm[2*k] - r_pm[2*k + 1];
            dn2 = r_pm[6 + 2*k] - r_pm[7 + 2*k];
            n_cross.n1[k] = dn1[dafp_pkg::CR_W-1:0];
            n_cross.n2[k] = dn2[dafp_pkg::CR_W-1:0];
            n_cross.a[k]  = r_a[k];
        end
        n_cross.bb = r_pm[12] + r_pm[13] + r_pm[14];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v           <= '0;
            r_cross.valid <= 1'b0;
        end else if (i_en) begin
            r_v           <= {r_v[2:0], i_valid};
            r_cross.valid <= n_cross.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d   <= n_d;
            r_d2  <= r_d;
            r_len <= n_len;
            r_s   <= n_s;
            r_pm  <= n_pm;
            for (int k = 0; k < 3; k++) begin
                r_a[k] <= r_s[k];
            end
            r_cross.n1 <= n_cross.n1;
            r_cross.n2 <= n_cross.n2;
            r_cross.a  <= n_cross.a;
            r_cross.bb <= n_cross.bb;
        end
    end

    assign o_cross = r_cross;

endmodule

>>> hdl/dafp_dot.sv
module dafp_dot (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  dafp_pkg::t_cross i_cross,
    output dafp_pkg::t_dot   o_dot
);
    localparam int HF = dafp_pkg::HF_W;
    localparam int MG = dafp_pkg::MG_W;

    logic [3:0]                   r_v;
    logic [dafp_pkg::BB_W-1:0]    r_bb [4];

    // magnitudes and signs
    logic [MG-1:0]                r_m1 [3];
    logic [MG-1:0]                r_m2 [3];
    logic [HF-1:0]                r_ma [3];
    logic [2:0]                   r_sx;
    logic [2:0]                   r_st;
    // chunk products
    logic [dafp_pkg::PP_W-1:0]    r_hh [3];
    logic [dafp_pkg::PP_W-1:0]    r_hl [3];
    logic [dafp_pkg::PP_W-1:0]    r_lh [3];
    logic [dafp_pkg::PP_W-1:0]    r_ll [3];
    logic [dafp_pkg::PP_W-1:0]    r_th [3];
    logic [dafp_pkg::PP_W-1:0]    r_tl [3];
    logic [2:0]                   r_sx2;
    logic [2:0]                   r_st2;
    // unsigned terms
    logic [dafp_pkg::PX_W-1:0]    r_px [3];
    logic [dafp_pkg::PT_W-1:0]    r_pt [3];
    logic [2:0]                   r_sx3;
    logic [2:0]                   r_st3;
    // signed terms
    logic [dafp_pkg::XT_W-1:0]    r_xt [3];
    logic [dafp_pkg::TT_W-1:0]    r_tt [3];

    logic [MG-1:0]                n_m1 [3];
    logic [MG-1:0]                n_m2 [3];
    logic [HF-1:0]                n_ma [3];
    logic [dafp_pkg::PX_W-1:0]    n_px [3];
    logic [dafp_pkg::PT_W-1:0]    n_pt [3];
    logic [dafp_pkg::XT_W-1:0]    n_xt [3];
    logic [dafp_pkg::TT_W-1:0]    n_tt [3];
    dafp_pkg::t_dot               n_dot;
    dafp_pkg::t_dot               r_dot;

    always_comb begin
        logic [dafp_pkg::CR_W-1:0] t1;
        logic [dafp_pkg::CR_W-1:0] t2;
        logic [dafp_pkg::SC_W-1:0] ta;
        for (int k = 0; k < 3; k++) begin
            t1 = i_cross.n1[k][dafp_pkg::CR_W-1] ? (~i_cross.n1[k] + 1'b1) : i_cross.n1[k];
            t2 = i_cross.n2[k][dafp_pkg::CR_W-1] ? (~i_cross.n2[k] + 1'b1) : i_cross.n2[k];
            ta = i_cross.a[k][dafp_pkg::SC_W-1] ? (~i_cross.a[k] + 1'b1) : i_cross.a[k];
            n_m1[k] = t1[MG-1:0];
            n_m2[k] = t2[MG-1:0];
            n_ma[k] = ta[HF-1:0];
        end
    end

    always_comb begin
        logic [dafp_pkg::PP_W:0] mid;
        for (int k = 0; k < 3; k++) begin
            mid     = {1'b0, r_hl[k]} + {1'b0, r_lh[k]};
            n_px[k] = {r_hh[k], {dafp_pkg::PP_W{1'b0}}}
                    + {{(dafp_pkg::PX_W-dafp_pkg::PP_W-1-HF){1'b0}}, mid, {HF{1'b0}}}
                    + {{(dafp_pkg::PX_W-dafp_pkg::PP_W){1'b0}}, r_ll[k]};
            n_pt[k] = dafp_pkg::PT_W'({r_th[k], {HF{1'b0}}})
                    + {{(dafp_pkg::PT_W-dafp_pkg::PP_W){1'b0}}, r_tl[k]};
        end
    end

    always_comb begin
        logic [dafp_pkg::XT_W-1:0] ex;
        logic [dafp_pkg::TT_W-1:0] et;
        for (int k = 0; k < 3; k++) begin
            ex      = {1'b0, r_px[k]};
            et      = {1'b0, r_pt[k]};
            n_xt[k] = r_sx3[k] ? (~ex + 1'b1) : ex;
            n_tt[k] = r_st3[k] ? (~et + 1'b1) : et;
        end
    end

    always_comb begin
        n_dot.valid = r_v[3];
        n_dot.x = {r_xt[0][dafp_pkg::XT_W-1], r_xt[0]}
                + {r_xt[1][dafp_pkg::XT_W-1], r_xt[1]}
                + {r_xt[2][dafp_pkg::XT_W-1], r_xt[2]};
        n_dot.t = {r_tt[0][dafp_pkg::TT_W-1], r_tt[0][dafp_pkg::TT_W-1], r_tt[0]}
                + {r_tt[1][dafp_pkg::TT_W-1], r_tt[1][dafp_pkg::TT_W-1], r_tt[1]}
                + {r_tt[2][dafp_pkg::TT_W-1], r_tt[2][dafp_pkg::TT_W-1], r_tt[2]};
        n_dot.bb = r_bb[3];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v         <= '0;
            r_dot.valid <= 1'b0;
        end else if (i_en) begin
            r_v         <= {r_v[2:0], i_cross.valid};
            r_dot.valid <= n_dot.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_bb[0] <= i_cross.bb;
            for (int s = 1; s < 4; s++) begin
                r_bb[s] <= r_bb[s-1];
            end
            r_m1 <= n_m1;
            r_m2 <= n_m2;
            r_ma <= n_ma;
            for (int k = 0; k < 3; k++) begin
                r_sx[k]  <= i_cross.n1[k][dafp_pkg::CR_W-1] ^ i_cross.n2[k][dafp_pkg::CR_W-1];
                r_st[k]  <= i_cross.a[k][dafp_pkg::SC_W-1] ^ i_cross.n2[k][dafp_pkg::CR_W-1];
                r_hh[k]  <= r_m1[k][MG-1:HF] * r_m2[k][MG-1:HF];
                r_hl[k]  <= r_m1[k][MG-1:HF] * r_m2[k][HF-1:0];
                r_lh[k]  <= r_m1[k][HF-1:0]  * r_m2[k][MG-1:HF];
                r_ll[k]  <= r_m1[k][HF-1:0]  * r_m2[k][HF-1:0];
                r_th[k]  <= r_ma[k] * r_m2[k][MG-1:HF];
                r_tl[k]  <= r_ma[k] * r_m2[k][HF-1:0];
            end
            r_sx2 <= r_sx;
            r_st2 <= r_st;
            r_px  <= n_px;
            r_pt  <= n_pt;
            r_sx3 <= r_sx2;
            r_st3 <= r_st2;
            r_xt  <= n_xt;
            r_tt  <= n_tt;
            r_dot.x  <= n_dot.x;
            r_dot.t  <= n_dot.t;
            r_dot.bb <= n_dot.bb;
        end
    end

    assign o_dot = r_dot;

endmodule

>>> hdl/dafp_sqrt.sv
module dafp_sqrt (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  dafp_pkg::t_dot  i_dot,
    output dafp_pkg::t_root o_root
);
    localparam int N  = dafp_pkg::SQ_N;
    localparam int BW = dafp_pkg::BB_W;

    logic [N-1:0]                 r_v;
    logic [BW-1:0]                r_rem [N];
    logic [BW-1:0]                r_res [N];
    logic [dafp_pkg::X_W-1:0]     r_x   [N];
    logic [dafp_pkg::T_W-1:0]     r_t   [N];

    // one result bit per stage, trial bit walking down from bit 62
    for (genvar j = 0; j < N; j++) begin : g_step
        localparam logic [BW-1:0] BIT = BW'(1) << (BW - 2 - 2*j);
        logic [BW-1:0] rem_in;
        logic [BW-1:0] res_in;
        logic [BW-1:0] trial;
        logic [BW-1:0] n_rem;
        logic [BW-1:0] n_res;
        logic          v_in;
        logic [dafp_pkg::X_W-1:0] x_in;
        logic [dafp_pkg::T_W-1:0] t_in;

        if (j == 0) begin : g_first
            assign rem_in = i_dot.bb;
            assign res_in = '0;
            assign v_in   = i_dot.valid;
            assign x_in   = i_dot.x;
            assign t_in   = i_dot.t;
        end else begin : g_next
            assign rem_in = r_rem[j-1];
            assign res_in = r_res[j-1];
            assign v_in   = r_v[j-1];
            assign x_in   = r_x[j-1];
            assign t_in   = r_t[j-1];
        end

        always_comb begin
            trial = res_in + BIT;
            if (rem_in >= trial) begin
                n_rem = rem_in - trial;
                n_res = (res_in >> 1) + BIT;
            end else begin
                n_rem = rem_in;
                n_res = res_in >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (i_en) begin
                r_v[j] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= n_rem;
                r_res[j] <= n_res;
                r_x[j]   <= x_in;
                r_t[j]   <= t_in;
            end
        end
    end

    assign o_root.valid = r_v[N-1];
    assign o_root.x     = r_x[N-1];
    assign o_root.t     = r_t[N-1];
    assign o_root.rb    = r_res[N-1][dafp_pkg::RB_W-1:0];

endmodule

>>> hdl/dafp_norm.sv
module dafp_norm (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  dafp_pkg::t_root i_root,
    output dafp_pkg::t_norm o_norm
);
    localparam int HF = dafp_pkg::HF_W;
    localparam int NW = dafp_pkg::PX_W;
    localparam int PP = dafp_pkg::PP_W;

    logic [3:0]                   r_v;
    logic [3:0]                   r_xneg;
    logic [3:0]                   r_tneg;
    logic [NW-1:0]                r_xm [4];
    logic [dafp_pkg::TM_W-1:0]    r_tm;
    logic [dafp_pkg::RB_W-1:0]    r_rb;
    logic [PP-1:0]                r_p  [3];
    logic [NW-1:0]                r_ym [2];
    logic [dafp_pkg::LN_W-1:0]    r_len;

    logic [NW-1:0]                n_xm;
    logic [dafp_pkg::TM_W-1:0]    n_tm;
    logic [NW-1:0]                n_ym;
    dafp_pkg::t_norm              n_norm;
    dafp_pkg::t_norm              r_norm;

    always_comb begin
        logic [dafp_pkg::X_W-1:0] ax;
        logic [dafp_pkg::T_W-1:0] at;
        ax   = i_root.x[dafp_pkg::X_W-1] ? (~i_root.x + 1'b1) : i_root.x;
        at   = i_root.t[dafp_pkg::T_W-1] ? (~i_root.t + 1'b1) : i_root.t;
        n_xm = ax[NW-1:0];
        n_tm = at[dafp_pkg::TM_W-1:0];
    end

    assign n_ym = {r_p[2], {PP{1'b0}}}
                + {{(NW-PP-HF){1'b0}}, r_p[1], {HF{1'b0}}}
                + {{(NW-PP){1'b0}}, r_p[0]};

    // scale both magnitudes so the larger has a 30 bit length
    always_comb begin
        logic [NW-1:0]             xsh;
        logic [NW-1:0]             ysh;
        logic [dafp_pkg::OP_W:0]   ye;
        if (r_len > dafp_pkg::LN_W'(dafp_pkg::SC_LEN)) begin
            xsh = r_xm[3]  >> (r_len - dafp_pkg::LN_W'(dafp_pkg::SC_LEN));
            ysh = r_ym[1]  >> (r_len - dafp_pkg::LN_W'(dafp_pkg::SC_LEN));
        end else begin
            xsh = r_xm[3]  << (dafp_pkg::LN_W'(dafp_pkg::SC_LEN) - r_len);
            ysh = r_ym[1]  << (dafp_pkg::LN_W'(dafp_pkg::SC_LEN) - r_len);
        end
        ye           = {1'b0, ysh[dafp_pkg::OP_W-1:0]};
        n_norm.valid = r_v[3];
        n_norm.zero  = (r_len == '0);
        n_norm.xneg  = r_xneg[3];
        n_norm.xs    = xsh[dafp_pkg::OP_W-1:0];
        n_norm.ys    = r_tneg[3] ? (~ye + 1'b1) : ye;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v          <= '0;
            r_norm.valid <= 1'b0;
        end else if (i_en) begin
            r_v          <= {r_v[2:0], i_root.valid};
            r_norm.valid <= n_norm.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xneg  <= {r_xneg[2:0], i_root.x[dafp_pkg::X_W-1]};
            r_tneg  <= {r_tneg[2:0], i_root.t[dafp_pkg::T_W-1]};
            r_xm[0] <= n_xm;
            for (int s = 1; s < 4; s++) begin
                r_xm[s] <= r_xm[s-1];
            end
            r_tm    <= n_tm;
            r_rb    <= i_root.rb;
            r_p[0]  <= r_rb * r_tm[HF-1:0];
            r_p[1]  <= r_rb * r_tm[2*HF-1:HF];
            r_p[2]  <= r_rb * r_tm[3*HF-1:2*HF];
            r_ym[0] <= n_ym;
            r_ym[1] <= r_ym[0];
            r_len   <= dafp_pkg::bitlen128({{(128-NW){1'b0}}, r_xm[2] | r_ym[0]});
            r_norm.zero <= n_norm.zero;
            r_norm.xneg <= n_norm.xneg;
            r_norm.xs   <= n_norm.xs;
            r_norm.ys   <= n_norm.ys;
        end
    end

    assign o_norm = r_norm;

endmodule

>>> hdl/dafp_cordic.sv
module dafp_cordic #(
    parameter int ANGLE_ITERATIONS = 20
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  dafp_pkg::t_norm                  i_norm,
    output logic                             o_valid,
    output logic signed [dafp_pkg::ANG_W-1:0] o_angle
);
    localparam int NI = (ANGLE_ITERATIONS < dafp_pkg::ATAN_N) ?
                        ANGLE_ITERATIONS : dafp_pkg::ATAN_N;
    localparam int CW = dafp_pkg::CD_W;
    localparam int RW = CW + 1;

    logic [NI:0]              r_v;
    logic [NI:0]              r_zero;
    logic signed [CW-1:0]     r_x [NI+1];
    logic signed [CW-1:0]     r_y [NI+1];
    logic signed [CW-1:0]     r_z [NI+1];
    logic                     r_ov;
    logic signed [dafp_pkg::ANG_W-1:0] r_ang;

    logic signed [CW-1:0]     n_x0;
    logic signed [CW-1:0]     n_y0;
    logic signed [CW-1:0]     n_z0;
    logic signed [dafp_pkg::ANG_W-1:0] n_ang;

    // left half plane folded over with a start of plus or minus pi
    always_comb begin
        logic signed [CW-1:0] ye;
        ye   = CW'($signed(i_norm.ys));
        n_x0 = CW'($signed({1'b0, i_norm.xs}));
        if (i_norm.xneg) begin
            n_z0 = ye[CW-1] ? -dafp_pkg::PI_Q30 : dafp_pkg::PI_Q30;
            n_y0 = -ye;
        end else begin
            n_z0 = '0;
            n_y0 = ye;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_norm.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero[0] <= i_norm.zero;
            r_x[0]    <= n_x0;
            r_y[0]    <= n_y0;
            r_z[0]    <= n_z0;
        end
    end

    for (genvar i = 0; i < NI; i++) begin : g_iter
        localparam logic signed [CW-1:0] ATN = CW'($signed({1'b0, dafp_pkg::ATAN_TAB[i]}));
        logic signed [CW-1:0] n_x;
        logic signed [CW-1:0] n_y;
        logic signed [CW-1:0] n_z;

        always_comb begin
            if (!r_y[i][CW-1]) begin
                n_x = r_x[i] + (r_y[i] >>> i);
                n_y = r_y[i] - (r_x[i] >>> i);
                n_z = r_z[i] + ATN;
            end else begin
                n_x = r_x[i] - (r_y[i] >>> i);
                n_y = r_y[i] + (r_x[i] >>> i);
                n_z = r_z[i] - ATN;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else if (i_en) begin
                r_v[i+1] <= r_v[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_zero[i+1] <= r_zero[i];
                r_x[i+1]    <= n_x;
                r_y[i+1]    <= n_y;
                r_z[i+1]    <= n_z;
            end
        end
    end

    // round to 2^-16, clamp to plus or minus pi, zero for a degenerate item
    always_comb begin
        logic signed [RW-1:0] zr;
        logic signed [RW-1:0] rs;
        zr = RW'(r_z[NI]) + RW'(8192);
        rs = zr >>> dafp_pkg::RND_SH;
        if (r_zero[NI]) begin
            n_ang = '0;
        end else if (rs > RW'(dafp_pkg::ANG_MAX)) begin
            n_ang = dafp_pkg::ANG_W'(dafp_pkg::ANG_MAX);
        end else if (rs < -RW'(dafp_pkg::ANG_MAX)) begin
            n_ang = -dafp_pkg::ANG_W'(dafp_pkg::ANG_MAX);
        end else begin
            n_ang = rs[dafp_pkg::ANG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_ov <= r_v[NI];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ang <= n_ang;
        end
    end

    assign o_valid = r_ov;
    assign o_angle = r_ang;

endmodule

>>> tb/sv/dihedral_angle_four_points_checker.sv
`timescale 1ns / 1ps

module dihedral_angle_four_points_checker #(
    parameter int COORD_WIDTH      = 32,
    parameter int ANGLE_ITERATIONS = 20
) (
    input  logic i_clk,
    input  logic i_rst_n,
    dafp_pts_if.sink  pt_mon,
    dafp_ang_if.sink  ang_mon,
    output int   o_mismatches,
    output int   o_pending,
    output logic o_moved
);
    typedef logic signed [63:0]  t_s64;
    typedef logic signed [129:0] t_s130;

    logic signed [dafp_pkg::ANG_W-1:0] angle_queue[$];

    function automatic t_s64 coord(input logic [COORD_WIDTH-1:0] v);
        return t_s64'($signed(v));
    endfunction

    // bit length of a nonnegative value
    function automatic int blen(input logic [129:0] v);
        int n;
        n = 0;
        for (int i = 0; i < 130; i++) begin
            if (v[i]) begin
                n = i + 1;
            end
        end
        return n;
    endfunction

    function automatic void scale3(ref t_s64 v[3]);
        logic [63:0] m;
        int len;
        m = 0;
        for (int k = 0; k < 3; k++) begin
            if ((v[k] < 0 ? -v[k] : v[k]) > m) begin
                m = v[k] < 0 ? -v[k] : v[k];
            end
        end
        if (m == 0) begin
            return;
        end
        len = blen(130'(m));
        for (int k = 0; k < 3; k++) begin
            if (len > dafp_pkg::SC_LEN) begin
                v[k] = v[k] >>> (len - dafp_pkg::SC_LEN);
            end else begin
                v[k] = v[k] <<< (dafp_pkg::SC_LEN - len);
            end
        end
    endfunction

    function automatic logic [63:0] root64(input logic [63:0] v);
        logic [63:0] res, bt;
        res = 0;
        bt = 64'd1 << 62;
        while (bt > v) begin
            bt = bt >> 2;
        end
        while (bt != 0) begin
            if (v >= res + bt) begin
                v = v - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res;
    endfunction

    function automatic logic signed [dafp_pkg::ANG_W-1:0] torsion(input t_s64 p[12]);
        t_s64 a[3], b[3], c[3], n1[3], n2[3];
        t_s130 xw, tw, xm, ym, big;
        logic [63:0] rb;
        logic yneg, xneg;
        int len;
        t_s64 x, y, z, dx, dy, r;
        for (int k = 0; k < 3; k++) begin
            a[k] = p[3+k] - p[k];
            b[k] = p[6+k] - p[3+k];
            c[k] = p[9+k] - p[6+k];
        end
        scale3(a);
        scale3(b);
        scale3(c);
        n1[0] = a[1]*b[2] - a[2]*b[1];
        n1[1] = a[2]*b[0] - a[0]*b[2];
        n1[2] = a[0]*b[1] - a[1]*b[0];
        n2[0] = b[1]*c[2] - b[2]*c[1];
        n2[1] = b[2]*c[0] - b[0]*c[2];
        n2[2] = b[0]*c[1] - b[1]*c[0];
        xw = 0;
        tw = 0;
        for (int k = 0; k < 3; k++) begin
            xw = xw + t_s130'(n1[k]) * t_s130'(n2[k]);
            tw = tw + t_s130'(a[k]) * t_s130'(n2[k]);
        end
        rb = root64(b[0]*b[0] + b[1]*b[1] + b[2]*b[2]);
        xneg = xw < 0;
        xm = xneg ? -xw : xw;
        yneg = tw < 0;
        ym = t_s130'({66'd0, rb}) * (yneg ? -tw : tw);
        big = (xm < ym) ? ym : xm;
        len = blen(big);
        if (len == 0) begin
            return '0;
        end
        if (len > dafp_pkg::OP_W) begin
            x = t_s64'(xm >> (len - dafp_pkg::OP_W));
            y = t_s64'(ym >> (len - dafp_pkg::OP_W));
        end else begin
            x = t_s64'(xm << (dafp_pkg::OP_W - len));
            y = t_s64'(ym << (dafp_pkg::OP_W - len));
        end
        if (yneg) begin
            y = -y;
        end
        z = 0;
        if (xneg) begin
            z = (y >= 0) ? t_s64'(dafp_pkg::PI_Q30) : -t_s64'(dafp_pkg::PI_Q30);
            y = -y;
        end
        for (int k = 0; k < ANGLE_ITERATIONS && k < dafp_pkg::ATAN_N; k++) begin
            dx = y >>> k;
            dy = x >>> k;
            if (y >= 0) begin
                x = x + dx; y = y - dy; z = z + t_s64'(dafp_pkg::ATAN_TAB[k]);
            end else begin
                x = x - dx; y = y + dy; z = z - t_s64'(dafp_pkg::ATAN_TAB[k]);
            end
        end
        r = (z + 8192) >>> dafp_pkg::RND_SH;
        if (r > dafp_pkg::ANG_MAX) r = dafp_pkg::ANG_MAX;
        if (r < -dafp_pkg::ANG_MAX) r = -dafp_pkg::ANG_MAX;
        return dafp_pkg::ANG_W'(r);
    endfunction

    assign o_pending = angle_queue.size();
    assign o_moved = (pt_mon.valid && pt_mon.ready) || (ang_mon.valid && ang_mon.ready);

    initial o_mismatches = 0;

    always @(posedge i_clk) begin
        t_s64 pts[12];
        logic signed [dafp_pkg::ANG_W-1:0] want;
        if (i_rst_n && pt_mon.valid && pt_mon.ready) begin
            pts = '{coord(pt_mon.first_x), coord(pt_mon.first_y), coord(pt_mon.first_z),
                    coord(pt_mon.second_x), coord(pt_mon.second_y), coord(pt_mon.second_z),
                    coord(pt_mon.third_x), coord(pt_mon.third_y), coord(pt_mon.third_z),
                    coord(pt_mon.fourth_x), coord(pt_mon.fourth_y), coord(pt_mon.fourth_z)};
            angle_queue.push_back(torsion(pts));
        end
        if (i_rst_n && ang_mon.valid && ang_mon.ready) begin
            if (angle_queue.size() == 0) begin
                o_mismatches <= o_mismatches + 1;
                if (o_mismatches < 10)
                    $display("unexpected angle %0d", ang_mon.torsion_angle);
            end else begin
                want = angle_queue.pop_front();
                if (want !== ang_mon.torsion_angle) begin
                    o_mismatches <= o_mismatches + 1;
                    if (o_mismatches < 10)
                        $display("angle mismatch: expected %0d got %0d", want,
                                 ang_mon.torsion_angle);
                end
            end
        end
    end
endmodule

>>> tb/sv/dihedral_angle_four_points_top_tb.sv
`timescale 1ns / 1ps

module dihedral_angle_four_points_top_tb;
    localparam int LATENCY   = 69;
    localparam int WATCH_MAX = 4000;
    localparam int N_RANDOM  = 1750;

    logic i_clk = 0;
    logic i_rst_n = 0;
    int   mismatches, pending;
    logic moved;
    int   idle_pct, stall_pct;
    int   quiet;

    dafp_pts_if #(.COORD_WIDTH(32)) pt_if ();
    dafp_ang_if ang_if ();

    dihedral_angle_four_points_top i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_pt   (pt_if),
        .o_ang  (ang_if)
    );

    dihedral_angle_four_points_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .pt_mon      (pt_if),
        .ang_mon     (ang_if),
        .o_mismatches(mismatches),
        .o_pending   (pending),
        .o_moved     (moved)
    );

    always #1 i_clk = ~i_clk;

    // receiver stalls at the rate of the current phase
    always @(posedge i_clk) begin
        ang_if.ready <= ($urandom_range(99) >= stall_pct);
    end

    // watchdog: too long with no item moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || moved) begin
            quiet <= 0;
        end else if (pending > 0 || pt_if.valid) begin
            quiet <= quiet + 1;
            if (quiet >= WATCH_MAX) begin
                $display("dihedral_angle_four_points_top_tb: FAIL");
                $finish;
            end
        end
    end

    // present one point quadruple and hold it until accepted
    task automatic send_points(input logic [31:0] c[12]);
        while ($urandom_range(99) < idle_pct) begin
            pt_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        pt_if.valid    <= 1'b1;
        pt_if.first_x  <= c[0];  pt_if.first_y  <= c[1];  pt_if.first_z  <= c[2];
        pt_if.second_x <= c[3];  pt_if.second_y <= c[4];  pt_if.second_z <= c[5];
        pt_if.third_x  <= c[6];  pt_if.third_y  <= c[7];  pt_if.third_z  <= c[8];
        pt_if.fourth_x <= c[9];  pt_if.fourth_y <= c[10]; pt_if.fourth_z <= c[11];
        @(posedge i_clk);
        while (!pt_if.ready) begin
            @(posedge i_clk);
        end
    endtask

    // coordinate of random magnitude class, small offsets reach every scale
    function automatic logic [31:0] rand_coord(input int mode);
        case (mode)
            0: return $urandom();
            1: return 32'($signed($urandom_range(2000)) - 1000);
            2: return 32'($signed($urandom_range(16)) - 8);
            default: return $urandom() >>> $urandom_range(31);
        endcase
    endfunction

    initial begin
        logic [31:0] c[12];
        logic [31:0] b[3];
        int mode;
        pt_if.valid = 0;
        pt_if.first_x = 0;  pt_if.first_y = 0;  pt_if.first_z = 0;
        pt_if.second_x = 0; pt_if.second_y = 0; pt_if.second_z = 0;
        pt_if.third_x = 0;  pt_if.third_y = 0;  pt_if.third_z = 0;
        pt_if.fourth_x = 0; pt_if.fourth_y = 0; pt_if.fourth_z = 0;
        ang_if.ready = 1;
        idle_pct = 0;
        stall_pct = 0;
        quiet = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: all points coincident, both x and y zero
        c = '{default: 32'h0};
        send_points(c);
        // zero b: second and third points equal
        c = '{32'h0, 32'h0, 32'h0, 32'h10000, 32'h0, 32'h0,
              32'h10000, 32'h0, 32'h0, 32'h10000, 32'h10000, 32'h0};
        send_points(c);
        // collinear points
        c = '{32'h0, 32'h0, 32'h0, 32'h10000, 32'h0, 32'h0,
              32'h20000, 32'h0, 32'h0, 32'h30000, 32'h0, 32'h0};
        send_points(c);
        // trans: y zero, x negative, gives +pi
        c = '{32'h0, 32'h10000, 32'h0, 32'h0, 32'h0, 32'h0,
              32'h10000, 32'h0, 32'h0, 32'h10000, 32'hFFFF0000, 32'h0};
        send_points(c);
        // cis: zero angle
        c = '{32'h0, 32'h10000, 32'h0, 32'h0, 32'h0, 32'h0,
              32'h10000, 32'h0, 32'h0, 32'h10000, 32'h10000, 32'h0};
        send_points(c);
        // plus and minus ninety degrees
        c = '{32'h0, 32'h10000, 32'h0, 32'h0, 32'h0, 32'h0,
              32'h10000, 32'h0, 32'h0, 32'h10000, 32'h0, 32'h10000};
        send_points(c);
        c[11] = 32'hFFFF0000;
        send_points(c);
        // coordinate extremes
        c = '{32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
              32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
              32'h7FFFFFFF, 32'h80000000};
        send_points(c);
        c = '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
              32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
              32'h7FFFFFFF, 32'h7FFFFFFF};
        send_points(c);
        c = '{32'hFFFFFFFF, 32'h0, 32'h1, 32'h0, 32'h0, 32'h0,
              32'h1, 32'hFFFFFFFF, 32'h0, 32'h0, 32'h1, 32'hFFFFFFFF};
        send_points(c);
        c = '{default: 32'hFFFFFFFF};
        c[4] = 32'h0; c[6] = 32'h1; c[10] = 32'h55555555;
        send_points(c);

        // random phases; the first pause lets every result drain
        for (int ph = 0; ph < 5; ph++) begin
            pt_if.valid <= 1'b0;
            while (pending > 0) @(posedge i_clk);
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 86; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 86; end
                3: begin idle_pct = 33; stall_pct = 33; end
                default: begin idle_pct = 0; stall_pct = 0; end
            endcase
            for (int n = 0; n < N_RANDOM / 5; n++) begin
                mode = $urandom_range(3);
                for (int k = 0; k < 12; k++) c[k] = rand_coord(mode);
                case ($urandom_range(9))
                    // collinear: equal offsets between neighbors
                    0: for (int k = 0; k < 3; k++) begin
                        b[k] = rand_coord(2);
                        c[3+k] = c[k] + b[k];
                        c[6+k] = c[3+k] + b[k];
                        c[9+k] = c[6+k] + b[k];
                    end
                    // planar: all z equal, angle 0 or pi
                    1: begin c[5] = c[2]; c[8] = c[2]; c[11] = c[2]; end
                    // coincident middle points
                    2: for (int k = 0; k < 3; k++) c[6+k] = c[3+k];
                    default: ;
                endcase
                send_points(c);
            end
        end
        pt_if.valid <= 1'b0;
        stall_pct = 0;

        while (pending > 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("dihedral_angle_four_points_top_tb: PASS");
        end else begin
            $display("dihedral_angle_four_points_top_tb: FAIL");
        end
        $finish;
    end
endmodule

>>> filelist.f
hdl/dafp_pkg.sv
hdl/dafp_pts_if.sv
hdl/dafp_ang_if.sv
hdl/dafp_front.sv
hdl/dafp_dot.sv
hdl/dafp_sqrt.sv
hdl/dafp_norm.sv
hdl/dafp_cordic.sv
hdl/dihedral_angle_four_points_top.sv
tb/sv/dihedral_angle_four_points_checker.sv
tb/sv/dihedral_angle_four_points_top_tb.sv
